@@ sv/gcl_pkg.sv @@
// gcl_pkg: shared types and constants for the gaussian conditioning block
// no dependencies; imported by the channel interfaces and the top level
`default_nettype none

package gcl_pkg;

  localparam int DIM_W    = 4;
  localparam int OPCODE_W = 2;
  localparam int IDX_W    = 3;
  localparam int VAL_W    = 32;
  localparam int QW       = 35;                       // quotient magnitude bits
  localparam int CNT_W    = 6;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;
  localparam logic [QW-1:0]    Q_LIMIT   = 35'h4_0000_0000;   // 2^34
  localparam logic [CNT_W-1:0] DIV_STEPS = 6'd34;            // top quotient bit index

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD_COV  = 2'd0,
    OP_LOAD_MEAN = 2'd1,
    OP_OBSERVE   = 2'd2,
    OP_NONE      = 2'd3
  } opcode_t;

  typedef enum logic {
    KIND_COV  = 1'b0,
    KIND_MEAN = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RDD,
    ST_CAPD,
    ST_RDA,
    ST_RDB,
    ST_RDS,
    ST_CAPS,
    ST_MRA,
    ST_MRB,
    ST_MUL,
    ST_ABS,
    ST_DCHK,
    ST_DIV,
    ST_FIN,
    ST_SING
  } state_t;

endpackage

`default_nettype wire

@@ sv/gcl_ifs.sv @@
// gcl channel interfaces: input item, result item and configuration write
// depends on gcl_pkg for field widths
`default_nettype none

interface gcl_in_if import gcl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OPCODE_W-1:0]   opcode;
  logic [IDX_W-1:0]      row;
  logic [IDX_W-1:0]      col;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, opcode, row, col, value, input ready);
  modport sink   (input valid, opcode, row, col, value, output ready);
endinterface

interface gcl_out_if import gcl_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [VAL_W-1:0] result_value;
  logic                    singular;
  logic                    last;

  modport source (output valid, kind, out_row, out_col, result_value, singular, last,
                  input ready);
  modport sink   (input valid, kind, out_row, out_col, result_value, singular, last,
                  output ready);
endinterface

interface gcl_cfg_if import gcl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DIM_W-1:0] dimension;

  modport source (output valid, dimension, input ready);
  modport sink   (input valid, dimension, output ready);
endinterface

`default_nettype wire

@@ sv/gcl_ram.sv @@
// gcl_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module gcl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/gaussian_condition_on_last_top.sv @@
// gaussian_condition_on_last_top: conditions a gaussian on its last variable
// depends on gcl_pkg, gcl_ifs (channel interfaces) and gcl_ram
//
// in_ch carries items: load covariance entry, load mean entry, observe.
// Loads are taken while idle, back to back, and give no result. An observe item
// reads dimension n (clamped to 2..MAX_DIM), m = n-1, and emits m*m
// conditional covariance results row by row, then m conditional means, the
// final one flagged last; a zero last variance gives one singular result.
// in_ch.ready is high only while the sequencer is idle. cfg_ch is always
// ready and writes the dimension; write it only while the block is idle.
// Results leave through a one-item output register on out_ch, so a stall
// on out_ch holds the sequencer at its finish step without losing data.
// Each result goes through one shared multiplier and a restoring divider
// that makes one quotient bit per cycle; the divider steps are skipped
// when the quotient is seen to overflow. Stores are two small rams with
// registered read; their contents are undefined until loaded. Reset
// (rst_n low, synchronous) returns the sequencer to idle, empties the
// output register and sets dimension to 8.
`default_nettype none

module gaussian_condition_on_last_top import gcl_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input wire logic clk,
  input wire logic rst_n,
  gcl_in_if.sink   in_ch,
  gcl_out_if.source out_ch,
  gcl_cfg_if.sink  cfg_ch
);

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW = $clog2(MAX_DIM * MAX_DIM);

  function automatic logic [AW-1:0] cov_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(AW'(r) * AW'(MAX_DIM) + AW'(c));
  endfunction

  // control state
  state_t           state_r, state_nxt;
  logic [DIM_W-1:0] dim_r;
  logic             out_valid_r;
  logic             phase_r;         // KIND_COV while walking covariance, then KIND_MEAN
  logic [IW-1:0]    i_r, j_r, m_r;
  logic [CNT_W-1:0] cnt_r;

  // datapath
  logic signed [VAL_W-1:0] obs_r, d_r, opa_r, base_r;
  logic signed [VAL_W:0]   opb_r, diff_r;
  logic [VAL_W-1:0]        dmag_r;
  logic signed [64:0]      prod_r;
  logic [63:0]             mag_r, rem_r;
  logic [65:0]             dv_r;
  logic [QW-1:0]           q_r;
  logic                    neg_r, ovf_r;

  // output register
  logic                    kind_r, sing_r, last_r;
  logic [IDX_W-1:0]        orow_r, ocol_r;
  logic signed [VAL_W-1:0] oval_r;

  // ram ports
  logic             cov_we, mean_we;
  logic [AW-1:0]    cov_raddr;
  logic [IW-1:0]    mean_raddr;
  logic [VAL_W-1:0] cov_rdata, mean_rdata;

  logic             in_fire, out_slot, out_load, i_end, j_end;
  logic [DIM_W-1:0] n_clamp, m_wide;
  logic             ovf_chk, div_take;
  logic [QW-1:0]    q_sat;
  logic signed [36:0] q_signed, sum;
  logic signed [VAL_W-1:0] res_val;
  opcode_t          op;

  assign op       = opcode_t'(in_ch.opcode);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_slot = !out_valid_r || out_ch.ready;
  assign i_end    = (i_r == m_r - IW'(1));
  assign j_end    = (j_r == m_r - IW'(1));

  always_comb begin
    n_clamp = dim_r;
    if (dim_r < 4'd2) begin
      n_clamp = 4'd2;
    end else if (int'(dim_r) > MAX_DIM) begin
      n_clamp = DIM_W'(MAX_DIM);
    end
    m_wide = n_clamp - 4'd1;
  end

  gcl_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DIM * MAX_DIM)) u_cov_ram (
    .clk   (clk),
    .we    (cov_we),
    .waddr (cov_addr(in_ch.row[IW-1:0], in_ch.col[IW-1:0])),
    .wdata (in_ch.value),
    .raddr (cov_raddr),
    .rdata (cov_rdata)
  );

  gcl_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DIM)) u_mean_ram (
    .clk   (clk),
    .we    (mean_we),
    .waddr (in_ch.row[IW-1:0]),
    .wdata (in_ch.value),
    .raddr (mean_raddr),
    .rdata (mean_rdata)
  );

  // divider compares
  assign ovf_chk  = {3'b000, mag_r} >= {dmag_r, 35'd0};
  assign div_take = {2'b00, rem_r} >= dv_r;

  // final combine: base +/- clamped quotient, saturated
  always_comb begin
    q_sat    = (ovf_r || (q_r > Q_LIMIT)) ? Q_LIMIT : q_r;
    q_signed = (neg_r ^ (phase_r == KIND_COV)) ? -$signed({2'b00, q_sat})
                                               : $signed({2'b00, q_sat});
    sum      = 37'(base_r) + q_signed;
    if (sum[36:31] == 6'b000000 || sum[36:31] == 6'b111111) begin
      res_val = sum[31:0];
    end else if (sum[36]) begin
      res_val = 32'sh8000_0000;
    end else begin
      res_val = 32'sh7fff_ffff;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && op == OP_OBSERVE) begin
          state_nxt = ST_RDD;
        end
      end
      ST_RDD:  state_nxt = ST_CAPD;
      ST_CAPD: state_nxt = (cov_rdata == '0) ? ST_SING : ST_RDA;
      ST_RDA:  state_nxt = ST_RDB;
      ST_RDB:  state_nxt = ST_RDS;
      ST_RDS:  state_nxt = ST_CAPS;
      ST_CAPS: state_nxt = ST_MUL;
      ST_MRA:  state_nxt = ST_MRB;
      ST_MRB:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ABS;
      ST_ABS:  state_nxt = ST_DCHK;
      ST_DCHK: state_nxt = ovf_chk ? ST_FIN : ST_DIV;
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_slot) begin
          priority if (phase_r == KIND_MEAN) begin
            state_nxt = i_end ? ST_IDLE : ST_MRA;
          end else if (j_end && i_end) begin
            state_nxt = ST_MRA;
          end else begin
            state_nxt = ST_RDA;
          end
        end
      end
      ST_SING: begin
        if (out_slot) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cov_raddr  = '0;
    mean_raddr = '0;
    cov_we     = 1'b0;
    mean_we    = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cov_we  = in_fire && op == OP_LOAD_COV && int'(in_ch.row) < MAX_DIM
                  && int'(in_ch.col) < MAX_DIM;
        mean_we = in_fire && op == OP_LOAD_MEAN && int'(in_ch.row) < MAX_DIM;
      end
      ST_RDD: begin
        cov_raddr  = cov_addr(m_r, m_r);
        mean_raddr = m_r;
      end
      ST_RDA:  cov_raddr = cov_addr(i_r, m_r);
      ST_RDB:  cov_raddr = cov_addr(j_r, m_r);
      ST_RDS:  cov_raddr = cov_addr(i_r, j_r);
      ST_MRA: begin
        cov_raddr  = cov_addr(i_r, m_r);
        mean_raddr = i_r;
      end
      ST_FIN, ST_SING: out_load = out_slot;
      default: ;
    endcase
  end

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dim_r       <= DIM_RESET;
      out_valid_r <= 1'b0;
      phase_r     <= KIND_COV;
      i_r         <= '0;
      j_r         <= '0;
      m_r         <= '0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        dim_r <= cfg_ch.dimension;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire && op == OP_OBSERVE) begin
        m_r     <= m_wide[IW-1:0];
        i_r     <= '0;
        j_r     <= '0;
        phase_r <= KIND_COV;
      end
      if (state_r == ST_DCHK) begin
        cnt_r <= DIV_STEPS;
      end else if (state_r == ST_DIV) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
      if (state_r == ST_FIN && out_slot) begin
        priority if (phase_r == KIND_MEAN) begin
          i_r <= i_r + IW'(1);
        end else if (j_end) begin
          j_r <= '0;
          if (i_end) begin
            i_r     <= '0;
            phase_r <= KIND_MEAN;
          end else begin
            i_r <= i_r + IW'(1);
          end
        end else begin
          j_r <= j_r + IW'(1);
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire && op == OP_OBSERVE) begin
      obs_r <= in_ch.value;
    end
    unique case (state_r)
      ST_CAPD: begin
        d_r    <= cov_rdata;
        dmag_r <= cov_rdata[VAL_W-1] ? (~cov_rdata + 32'd1) : cov_rdata;
        diff_r <= {obs_r[VAL_W-1], obs_r} - {mean_rdata[VAL_W-1], mean_rdata};
      end
      ST_RDB:  opa_r <= cov_rdata;
      ST_RDS:  opb_r <= {cov_rdata[VAL_W-1], cov_rdata};
      ST_CAPS: base_r <= cov_rdata;
      ST_MRB: begin
        opa_r  <= cov_rdata;
        base_r <= mean_rdata;
        opb_r  <= diff_r;
      end
      ST_MUL:  prod_r <= opa_r * opb_r;
      ST_ABS: begin
        mag_r <= prod_r[64] ? 64'(-prod_r) : prod_r[63:0];
        neg_r <= prod_r[64] ^ d_r[VAL_W-1];
      end
      ST_DCHK: begin
        ovf_r <= ovf_chk;
        rem_r <= mag_r;
        dv_r  <= {dmag_r, 34'd0};
        q_r   <= '0;
      end
      ST_DIV: begin
        if (div_take) begin
          rem_r <= rem_r - dv_r[63:0];
        end
        q_r  <= {q_r[QW-2:0], div_take};
        dv_r <= dv_r >> 1;
      end
      default: ;
    endcase
    if (out_load) begin
      if (state_r == ST_SING) begin
        kind_r <= KIND_COV;
        orow_r <= '0;
        ocol_r <= '0;
        oval_r <= '0;
        sing_r <= 1'b1;
        last_r <= 1'b1;
      end else begin
        kind_r <= phase_r;
        orow_r <= IDX_W'(i_r);
        ocol_r <= (phase_r == KIND_MEAN) ? '0 : IDX_W'(j_r);
        oval_r <= res_val;
        sing_r <= 1'b0;
        last_r <= (phase_r == KIND_MEAN) && i_end;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.out_row      = orow_r;
  assign out_ch.out_col      = ocol_r;
  assign out_ch.result_value = oval_r;
  assign out_ch.singular     = sing_r;
  assign out_ch.last         = last_r;

  // a result is only loaded into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("result loaded over a pending item");

  // the final result of a run always hands the sequencer back to idle
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (state_r == ST_SING || (phase_r == KIND_MEAN && i_end)))
      |=> (state_r == ST_IDLE))
    else $error("run did not end after last result");

  // walk indices stay inside the conditioned block
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RDA || state_r == ST_MRA) |-> (i_r < m_r && j_r < m_r))
    else $error("walk index beyond dimension");

  // the divider never runs when the quotient was already known to overflow
  a_div_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !ovf_r)
    else $error("divider running on an overflowed quotient");

endmodule

`default_nettype wire
